FILE: rtl/assert_macros.svh
// Assertion macros for the convolution engine.
// Needs clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cle_pkg.sv
// Shared types and constants of the convolution engine.
// No dependencies; used by cle_mac, conv2d_layer_engine and the testbench.
package cle_pkg;

  typedef enum logic [1:0] {
    REQ_FEATURE = 2'd0,
    REQ_WEIGHT  = 2'd1,
    REQ_BIAS    = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_t;

  localparam logic [2:0] CFG_IN_CHANNELS = 3'd0;
  localparam logic [2:0] CFG_IN_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_IN_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_STRIDE      = 3'd3;
  localparam logic [2:0] CFG_RELU_ENABLE = 3'd4;

  localparam logic [4:0] RST_IN_CHANNELS = 5'd1;
  localparam logic [5:0] RST_IN_HEIGHT   = 6'd28;
  localparam logic [5:0] RST_IN_WIDTH    = 6'd28;
  localparam logic [2:0] RST_STRIDE      = 3'd1;
  localparam logic       RST_RELU_ENABLE = 1'b1;

  // Output row/column times stride: 5-bit position by 3-bit stride
  localparam int BASE_W = 8;
  // Half an LSB of Q8.8 in the Q25.16 accumulator
  localparam int ROUND_HALF = 128;

  localparam logic signed [15:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Q_MIN = 16'sh8000;

  typedef struct packed {
    req_t               req_type;
    logic [3:0]         chan;
    logic [3:0]         out_chan;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [1:0]         tap_row;
    logic [1:0]         tap_col;
    logic signed [15:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic               saturated;
  } out_word_t;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic load;    // load accumulator with the bias
    logic live;    // a tap is issued this cycle
    logic tap_on;  // the issued tap lies inside the map
  } mac_ctl_t;

endpackage

FILE: rtl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cle_mac.sv
// Shared multiply-accumulate unit: product register, then accumulator.
// Depends on cle_pkg for the control struct.
module cle_mac import cle_pkg::*; #(
  parameter int ACC_W = 41
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [15:0]      bias,
  input  logic signed [15:0]      feat,
  input  logic signed [15:0]      wgt,
  output logic signed [ACC_W-1:0] acc,
  output logic                    busy
);

  logic                    live1_r, on1_r;
  logic                    live2_r, on2_r;
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;

  // Flags follow the RAM read latency, then the product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live1_r <= 1'b0;
      on1_r   <= 1'b0;
      live2_r <= 1'b0;
      on2_r   <= 1'b0;
    end else begin
      live1_r <= ctl.live;
      on1_r   <= ctl.live & ctl.tap_on;
      live2_r <= live1_r;
      on2_r   <= on1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= feat * wgt;
    if (ctl.load) begin
      acc_r <= $signed({{(ACC_W-24){bias[15]}}, bias, 8'h00});
    end else if (on2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = live1_r | live2_r;

endmodule

FILE: rtl/conv2d_layer_engine.sv
// Convolution engine, 3x3 multi-channel, zero padding, optional ReLU, Q8.8.
// Store words are taken while the sequencer is idle; a compute word passes bias load,
// one tap per cycle on the shared unit over the active input channels, and drain,
// and the next word is taken once its result is in the result register;
// Reset (synchronous, rst_n low) restores the configuration defaults and
// empties the sequencer and result register; the stores keep their contents.
`include "assert_macros.svh"

module conv2d_layer_engine import cle_pkg::*; #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16,
  parameter int MAX_SIDE         = 32,
  parameter int KERNEL           = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  // Derived sizes
  localparam int PAD     = (KERNEL - 1) / 2;
  localparam int F_DEPTH = MAX_IN_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KERNEL * KERNEL;
  localparam int FAW     = (F_DEPTH > 1) ? $clog2(F_DEPTH) : 1;
  localparam int WAW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int OCW     = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int CHW     = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int NCW     = $clog2(MAX_IN_CHANNELS + 1);
  localparam int HW      = $clog2(MAX_SIDE + 1);
  localparam int KW      = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int IXW     = 11;  // signed tap position: base + tap - pad
  localparam int ACC_W   = 33 + $clog2(MAX_IN_CHANNELS * KERNEL * KERNEL + 1);
  localparam int RW      = ACC_W - 7;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BIAS   = 5'b00010,
    S_RUN    = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [4:0] cfg_chan_r;
  logic [5:0] cfg_h_r;
  logic [5:0] cfg_w_r;
  logic [2:0] cfg_stride_r;
  logic       cfg_relu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_chan_r   <= RST_IN_CHANNELS;
      cfg_h_r      <= RST_IN_HEIGHT;
      cfg_w_r      <= RST_IN_WIDTH;
      cfg_stride_r <= RST_STRIDE;
      cfg_relu_r   <= RST_RELU_ENABLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_CHANNELS: cfg_chan_r   <= cfg_wdata[4:0];
        CFG_IN_HEIGHT:   cfg_h_r      <= cfg_wdata;
        CFG_IN_WIDTH:    cfg_w_r      <= cfg_wdata;
        CFG_STRIDE:      cfg_stride_r <= cfg_wdata[2:0];
        CFG_RELU_ENABLE: cfg_relu_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp the active sizes to what the stores hold
  logic [NCW-1:0] nch;
  logic [HW-1:0]  h_lim, w_lim;

  assign nch   = (32'(cfg_chan_r) > MAX_IN_CHANNELS) ? NCW'(MAX_IN_CHANNELS) : NCW'(cfg_chan_r);
  assign h_lim = (32'(cfg_h_r) > MAX_SIDE) ? HW'(MAX_SIDE) : HW'(cfg_h_r);
  assign w_lim = (32'(cfg_w_r) > MAX_SIDE) ? HW'(MAX_SIDE) : HW'(cfg_w_r);

  // Input acceptance and store writes
  logic in_acc;
  logic f_we, w_we, b_we, start;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  assign f_we = in_acc && (in_data.req_type == REQ_FEATURE)
             && (32'(in_data.chan) < MAX_IN_CHANNELS)
             && (32'(in_data.row) < MAX_SIDE) && (32'(in_data.col) < MAX_SIDE);
  assign w_we = in_acc && (in_data.req_type == REQ_WEIGHT)
             && (32'(in_data.out_chan) < MAX_OUT_CHANNELS)
             && (32'(in_data.chan) < MAX_IN_CHANNELS)
             && (32'(in_data.tap_row) < KERNEL) && (32'(in_data.tap_col) < KERNEL);
  assign b_we = in_acc && (in_data.req_type == REQ_BIAS)
             && (32'(in_data.out_chan) < MAX_OUT_CHANNELS);
  assign start = in_acc && (in_data.req_type == REQ_COMPUTE);

  logic [FAW-1:0] f_waddr, f_raddr;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [15:0]    f_rdata, w_rdata, b_rdata;

  assign f_waddr = FAW'((32'(in_data.chan) * MAX_SIDE + 32'(in_data.row)) * MAX_SIDE
                        + 32'(in_data.col));
  assign w_waddr = WAW'(((32'(in_data.out_chan) * MAX_IN_CHANNELS + 32'(in_data.chan))
                         * KERNEL + 32'(in_data.tap_row)) * KERNEL + 32'(in_data.tap_col));

  // Query context, held for the whole compute
  logic [3:0]        oc_r;
  logic              bad_oc_r;
  logic [BASE_W-1:0] rbase_r, cbase_r;
  logic [CHW-1:0]    ic_r;
  logic [KW-1:0]     kh_r, kw_r;

  // Tap position and bounds
  logic signed [IXW-1:0] ih, iw;
  logic                  row_ok, col_ok, last_tap;

  assign ih = $signed(IXW'(rbase_r)) + $signed(IXW'(kh_r)) - $signed(IXW'(PAD));
  assign iw = $signed(IXW'(cbase_r)) + $signed(IXW'(kw_r)) - $signed(IXW'(PAD));
  assign row_ok = (ih >= $signed(IXW'(0))) && (ih < $signed(IXW'(h_lim)));
  assign col_ok = (iw >= $signed(IXW'(0))) && (iw < $signed(IXW'(w_lim)));
  assign last_tap = (NCW'(ic_r) == nch - NCW'(1)) && (kh_r == KW'(KERNEL - 1))
                 && (kw_r == KW'(KERNEL - 1));

  // Read addresses are don't-care off the map: the product is dropped
  assign f_raddr = FAW'((32'(ic_r) * MAX_SIDE + 32'(ih[IXW-2:0])) * MAX_SIDE
                        + 32'(iw[IXW-2:0]));
  assign w_raddr = WAW'(((32'(oc_r) * MAX_IN_CHANNELS + 32'(ic_r)) * KERNEL
                         + 32'(kh_r)) * KERNEL + 32'(kw_r));

  cle_ram #(.WIDTH(16), .DEPTH(F_DEPTH)) u_feat_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (in_data.value),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  cle_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_data.value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Bias read follows the incoming word so the data is there in S_BIAS
  cle_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CHANNELS)) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (OCW'(in_data.out_chan)),
    .wdata (in_data.value),
    .raddr (OCW'(in_data.out_chan)),
    .rdata (b_rdata)
  );

  // Shared multiply-accumulate unit
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_busy;

  assign mac_ctl.load   = (state_r == S_BIAS);
  assign mac_ctl.live   = (state_r == S_RUN);
  assign mac_ctl.tap_on = row_ok & col_ok;

  cle_mac #(.ACC_W(ACC_W)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .bias  (bad_oc_r ? 16'sd0 : $signed(b_rdata)),
    .feat  ($signed(f_rdata)),
    .wgt   ($signed(w_rdata)),
    .acc   (acc),
    .busy  (mac_busy)
  );

  // Round half up to Q8.8, optional ReLU, saturate to 16 bits
  logic signed [ACC_W:0]  rnd;
  logic signed [RW-1:0]   res, res_relu;
  logic                   sat_hi, sat_lo;
  out_word_t              result;

  assign rnd      = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(ROUND_HALF));
  assign res      = $signed(rnd[ACC_W:8]);
  assign res_relu = (cfg_relu_r && (res < $signed(RW'(0)))) ? $signed(RW'(0)) : res;
  assign sat_hi   = res_relu > RW'(Q_MAX);
  assign sat_lo   = res_relu < RW'(Q_MIN);

  assign result.out_value = sat_hi ? Q_MAX : (sat_lo ? Q_MIN : res_relu[15:0]);
  assign result.saturated = sat_hi | sat_lo;

  // Result register: parts the sequencer from the output handshake
  logic      out_valid_r;
  out_word_t out_data_r;
  logic      out_free, out_load;

  assign out_free = ~out_valid_r | ~out_stall;
  assign out_load = (state_r == S_FINISH) && out_free;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_BIAS;
      S_BIAS:   state_nxt = (bad_oc_r || (nch == NCW'(0))) ? S_DRAIN : S_RUN;
      S_RUN:    if (last_tap) state_nxt = S_DRAIN;
      S_DRAIN:  if (!mac_busy) state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Query context and tap counters: kw innermost, then kh, then channel
  always_ff @(posedge clk) begin
    if (start) begin
      oc_r     <= in_data.out_chan;
      bad_oc_r <= (32'(in_data.out_chan) >= MAX_OUT_CHANNELS);
      rbase_r  <= BASE_W'(in_data.row) * BASE_W'(cfg_stride_r);
      cbase_r  <= BASE_W'(in_data.col) * BASE_W'(cfg_stride_r);
      ic_r     <= '0;
      kh_r     <= '0;
      kw_r     <= '0;
    end else if (state_r == S_RUN) begin
      if (kw_r == KW'(KERNEL - 1)) begin
        kw_r <= '0;
        if (kh_r == KW'(KERNEL - 1)) begin
          kh_r <= '0;
          ic_r <= ic_r + CHW'(1);
        end else begin
          kh_r <= kh_r + KW'(1);
        end
      end else begin
        kw_r <= kw_r + KW'(1);
      end
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and the result path
  `CLE_ASSERT_NEXT(a_start_bias, start, state_r == S_BIAS, "compute did not start")
  `CLE_ASSERT_NOW(a_run_bounds, state_r == S_RUN,
    (NCW'(ic_r) < nch) && (32'(kh_r) < KERNEL) && (32'(kw_r) < KERNEL),
    "tap counter out of range")
  `CLE_ASSERT_NOW(a_finish_idle, state_r == S_FINISH, !mac_busy, "result taken with taps in flight")
  `CLE_ASSERT_NOW(a_out_src, $rose(out_valid_r), $past(state_r == S_FINISH),
    "result word without a finished compute")

endmodule

FILE: test/testbench.sv
// Self-checking bench for conv2d_layer_engine: store writes, 3x3 queries, padding, ReLU.
// Depends on cle_pkg for the word types, request kinds and register indexes.
// Holds its own convolution predictor; drives valid/stall channels and the config port.
module testbench;
  import cle_pkg::*;

  localparam int N_IN  = 16;
  localparam int N_OUT = 16;
  localparam int SIDE  = 32;
  localparam int TAPS  = 3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [5:0] cfg_wdata = '0;

  function automatic int clip(int v, int cap);
    return (v > cap) ? cap : v;
  endfunction

  // Mirror of the engine: stores, registers and the queue of predicted results.
  class conv_tracker;
    logic signed [15:0] feature_mem [N_IN][SIDE][SIDE];
    logic signed [15:0] weight_mem [N_OUT][N_IN][TAPS][TAPS];
    logic signed [15:0] bias_mem [N_OUT];
    int n_in = RST_IN_CHANNELS;
    int height = RST_IN_HEIGHT;
    int width = RST_IN_WIDTH;
    int step = RST_STRIDE;
    int relu = RST_RELU_ENABLE;
    out_word_t predicted [$];
    int failures = 0;
    int seen = 0;

    function void set_reg(logic [2:0] idx, logic [5:0] val);
      case (idx)
        CFG_IN_CHANNELS: n_in = val[4:0];
        CFG_IN_HEIGHT:   height = val;
        CFG_IN_WIDTH:    width = val;
        CFG_STRIDE:      step = val[2:0];
        CFG_RELU_ENABLE: relu = val[0];
        default: ;
      endcase
    endfunction

    // Sum bias and products over active channels and in-map taps, round, clamp.
    function out_word_t conv_point(in_word_t w);
      longint acc;
      int nch, h, wd, ih, iw;
      out_word_t res;
      nch = clip(n_in, N_IN);
      h = clip(height, SIDE);
      wd = clip(width, SIDE);
      acc = longint'(bias_mem[w.out_chan]) * 256;
      for (int ic = 0; ic < nch; ic++)
        for (int kh = 0; kh < TAPS; kh++)
          for (int kw = 0; kw < TAPS; kw++) begin
            ih = int'(w.row) * step + kh - 1;
            iw = int'(w.col) * step + kw - 1;
            if (ih >= 0 && ih < h && iw >= 0 && iw < wd)
              acc += longint'(feature_mem[ic][ih][iw]) *
                     longint'(weight_mem[w.out_chan][ic][kh][kw]);
          end
      // half rounds towards plus infinity
      acc = (acc + 128) >>> 8;
      if (relu != 0 && acc < 0) acc = 0;
      res.saturated = 1'b0;
      if (acc > 32767) begin
        acc = 32767;
        res.saturated = 1'b1;
      end else if (acc < -32768) begin
        acc = -32768;
        res.saturated = 1'b1;
      end
      res.out_value = acc[15:0];
      return res;
    endfunction

    function void note_word(in_word_t w);
      case (w.req_type)
        REQ_FEATURE: feature_mem[w.chan][w.row][w.col] = w.value;
        REQ_WEIGHT:
          if (w.tap_row < TAPS && w.tap_col < TAPS)
            weight_mem[w.out_chan][w.chan][w.tap_row][w.tap_col] = w.value;
        REQ_BIAS:    bias_mem[w.out_chan] = w.value;
        default:     predicted.push_back(conv_point(w));
      endcase
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      failures++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      seen++;
      if (predicted.size() == 0) begin
        report($sformatf("result %0d arrived with none pending (%0d, sat %0b)",
                         seen, got.out_value, got.saturated));
        return;
      end
      want = predicted.pop_front();
      if (got.out_value !== want.out_value)
        report($sformatf("result %0d out_value %0d, predicted %0d",
                         seen, got.out_value, want.out_value));
      if (got.saturated !== want.saturated)
        report($sformatf("result %0d saturated %0b, predicted %0b",
                         seen, got.saturated, want.saturated));
    endtask
  endclass

  conv_tracker sb = new();

  // Which store entries hold a value; a query only ever reads written entries.
  bit feat_set [N_IN][SIDE][SIDE];
  bit weight_set [N_OUT][N_IN][TAPS][TAPS];
  bit bias_set [N_OUT];

  int done_items = 0;
  bit quiet = 1'b0;
  int span = 256;

  conv2d_layer_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Result side: check every accepted word, then pick the next stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_data);
    out_stall <= !quiet && ($urandom_range(0, 99) < 14);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40000000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic signed [15:0] rand_q();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1)
      case ($urandom_range(0, 3))
        0:       return Q_MAX;
        1:       return Q_MIN;
        2:       return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // Offer one word, hold it until accepted, then log it with the tracker.
  task automatic send_word(in_word_t w);
    if (!quiet)
      while ($urandom_range(0, 99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic put_word(input req_t kind, input logic [3:0] ch, input logic [3:0] oc,
                          input logic [4:0] r, input logic [4:0] c,
                          input logic [1:0] tr, input logic [1:0] tc,
                          input logic signed [15:0] v);
    in_word_t w;
    bit ignored;
    w = '0;
    w.req_type = kind;
    w.chan = ch;
    w.out_chan = oc;
    w.row = r;
    w.col = c;
    w.tap_row = tr;
    w.tap_col = tc;
    w.value = v;
    ignored = 1'b0;
    case (kind)
      REQ_FEATURE: feat_set[ch][r][c] = 1'b1;
      REQ_WEIGHT:
        if (tr < TAPS && tc < TAPS) weight_set[oc][ch][tr][tc] = 1'b1;
        else ignored = 1'b1;
      REQ_BIAS:    bias_set[oc] = 1'b1;
      default: ;
    endcase
    send_word(w);
    if (!ignored) done_items++;
  endtask

  // Write whatever the query at (oc, r, c) would read that still lies unwritten, then ask.
  task automatic ask(input logic [3:0] oc, input logic [4:0] r, input logic [4:0] c,
                     input bit use_fixed, input logic signed [15:0] fixed);
    int nch, h, wd, ih, iw;
    nch = clip(sb.n_in, N_IN);
    h = clip(sb.height, SIDE);
    wd = clip(sb.width, SIDE);
    if (!bias_set[oc])
      put_word(REQ_BIAS, 4'd0, oc, 5'd0, 5'd0, 2'd0, 2'd0, use_fixed ? fixed : rand_q());
    for (int ic = 0; ic < nch; ic++)
      for (int kh = 0; kh < TAPS; kh++)
        for (int kw = 0; kw < TAPS; kw++) begin
          ih = int'(r) * sb.step + kh - 1;
          iw = int'(c) * sb.step + kw - 1;
          if (ih >= 0 && ih < h && iw >= 0 && iw < wd) begin
            if (!weight_set[oc][ic][kh][kw])
              put_word(REQ_WEIGHT, 4'(ic), oc, 5'd0, 5'd0, 2'(kh), 2'(kw),
                       use_fixed ? fixed : rand_q());
            if (!feat_set[ic][ih][iw])
              put_word(REQ_FEATURE, 4'(ic), 4'd0, 5'(ih), 5'(iw), 2'd0, 2'd0,
                       use_fixed ? fixed : rand_q());
          end
        end
    put_word(REQ_COMPUTE, 4'($urandom), oc, r, c, 2'($urandom), 2'($urandom), 16'($urandom));
  endtask

  // Drop valid and hold until every predicted result is out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [5:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(int ch, int h, int wd, int s, int relu);
    put_reg(CFG_IN_CHANNELS, 6'(ch));
    put_reg(CFG_IN_HEIGHT, 6'(h));
    put_reg(CFG_IN_WIDTH, 6'(wd));
    put_reg(CFG_STRIDE, 6'(s));
    put_reg(CFG_RELU_ENABLE, 6'(relu));
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int pick, nch, h, wd, rows, cols;
    logic [4:0] r, c;
    logic [1:0] tr, tc;
    nch = clip(sb.n_in, N_IN);
    h = clip(sb.height, SIDE);
    wd = clip(sb.width, SIDE);
    // output extent that still touches the map
    rows = (sb.step == 0 || h == 0) ? 1 : clip((h - 1) / sb.step + 2, SIDE);
    cols = (sb.step == 0 || wd == 0) ? 1 : clip((wd - 1) / sb.step + 2, SIDE);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r = 5'($urandom_range(0, rows - 1));
      c = 5'($urandom_range(0, cols - 1));
      ask(4'($urandom), r, c, 1'b0, 16'sh0);
    end else if (pick < 52) begin
      put_word(REQ_FEATURE, 4'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
               2'($urandom), 2'($urandom), rand_q());
    end else if (pick < 66) begin
      // refresh a value inside the active area
      r = (h == 0) ? 5'($urandom) : 5'($urandom_range(0, h - 1));
      c = (wd == 0) ? 5'($urandom) : 5'($urandom_range(0, wd - 1));
      put_word(REQ_FEATURE, (nch == 0) ? 4'($urandom) : 4'($urandom_range(0, nch - 1)),
               4'($urandom), r, c, 2'($urandom), 2'($urandom), rand_q());
    end else if (pick < 82) begin
      // now and then a tap index of three, which the engine must drop
      tr = ($urandom_range(0, 99) < 8) ? 2'd3 : 2'($urandom_range(0, 2));
      tc = ($urandom_range(0, 99) < 8) ? 2'd3 : 2'($urandom_range(0, 2));
      put_word(REQ_WEIGHT, 4'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
               tr, tc, rand_q());
    end else if (pick < 90) begin
      put_word(REQ_BIAS, 4'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
               2'($urandom), 2'($urandom), rand_q());
    end else begin
      ask(4'($urandom), 5'($urandom), 5'($urandom), 1'b0, 16'sh0);
    end
  endtask

  task automatic run_phase(int ch, int h, int wd, int s, int relu, int count, int mag,
                           bit hold_mid);
    int goal;
    bit held;
    drain();
    set_config(ch, h, wd, s, relu);
    span = mag;
    goal = done_items + count;
    held = 1'b0;
    while (done_items < goal) begin
      random_item();
      // pause the sender until the engine has caught up completely
      if (hold_mid && !held && done_items >= goal - count / 2) begin
        held = 1'b1;
        drain();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration: one channel, 28x28, stride one, ReLU on.
    put_word(REQ_BIAS, 4'd0, 4'd0, 5'd0, 5'd0, 2'd0, 2'd0, Q_MAX);
    // tap row out of range: dropped, nothing may change
    put_word(REQ_WEIGHT, 4'd0, 4'd0, 5'd0, 5'd0, 2'd3, 2'd0, 16'sh1234);
    // far corner lies outside the active map: stored, never read
    put_word(REQ_FEATURE, 4'd15, 4'd0, 5'd31, 5'd31, 2'd0, 2'd0, Q_MAX);
    put_word(REQ_FEATURE, 4'd0, 4'd0, 5'd0, 5'd0, 2'd0, 2'd0, Q_MIN);
    // top-left corner with padding, driven into positive saturation
    ask(4'd0, 5'd0, 5'd0, 1'b1, Q_MAX);
    // bottom-right corner with padding, also driven into positive saturation
    ask(4'd0, 5'd27, 5'd27, 1'b1, Q_MIN);
    // every tap off the map: bias alone, negative, clamped by ReLU
    put_word(REQ_BIAS, 4'd0, 4'd1, 5'd0, 5'd0, 2'd0, 2'd0, Q_MIN);
    ask(4'd1, 5'd31, 5'd31, 1'b0, 16'sh0);

    // Long stretch without idling on either side, full-size layer.
    quiet = 1'b1;
    run_phase(16, 32, 32, 1, 0, 180, 32767, 1'b0);
    quiet = 1'b0;
    run_phase(0, 5, 7, 2, 0, 180, 256, 1'b1);
    run_phase(31, 63, 63, 7, 1, 180, 4096, 1'b0);
    run_phase(3, 0, 9, 0, 0, 180, 4096, 1'b0);
    run_phase(1, 1, 1, 4, 0, 180, 256, 1'b0);
    run_phase(2, 32, 1, 3, 1, 180, 1024, 1'b0);
    repeat (3)
      run_phase(($urandom_range(0, 99) < 70) ? $urandom_range(0, 5) : $urandom_range(0, 31),
                $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 7),
                $urandom_range(0, 1), 180, ($urandom_range(0, 1) != 0) ? 512 : 8192,
                1'b0);

    drain();
    // leave room for any stray result to show up
    repeat (160) @(posedge clk);
    if (sb.failures == 0 && sb.predicted.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
